@@ rtl/core/gsrp_pkg.sv @@
// ----------------------------------------------------------------------------
// gsrp_pkg
// Types and constants shared by the general status reply parser modules.
// ----------------------------------------------------------------------------
package gsrp_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_marker;
  } in_t;

  typedef struct packed {
    logic [4:0]  field_index;
    logic [15:0] value;
    logic        done_res;
    logic [1:0]  status;
    logic        last_of_run;
  } out_t;

  typedef enum logic [2:0] {
    K_X10  = 3'd0,
    K_X100 = 3'd1,
    K_U16  = 3'd2,
    K_U8   = 3'd3,
    K_B8   = 3'd4,
    K_B3   = 3'd5,
    K_NONE = 3'd6
  } kind_e;

  typedef struct packed {
    logic [4:0]  idx;
    kind_e       kind;
    logic [15:0] acc;
    logic        sat;
    logic        neg;
    logic [6:0]  frac;
    logic [7:0]  bits;
  } tok_t;

  typedef struct packed {
    logic       has_field;
    tok_t       tok;
    logic       has_status;
    logic [1:0] status;
  } entry_t;

  localparam int NUM_FIELDS = 24;
  localparam int MIN_FIELDS = 20;
  localparam int QDEPTH     = 4;
  localparam int QAW        = 2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_PAREN = 2'd1;
  localparam logic [1:0] ST_FEW      = 2'd2;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  function automatic kind_e kind_of(input logic [4:0] idx);
    kind_e k;
    case (idx)
      5'd0, 5'd1, 5'd2, 5'd3, 5'd12, 5'd13:                 k = K_X10;
      5'd8, 5'd14:                                          k = K_X100;
      5'd4, 5'd5, 5'd7, 5'd9, 5'd11, 5'd15, 5'd17, 5'd19,
      5'd23:                                                k = K_U16;
      5'd6, 5'd10, 5'd18, 5'd21, 5'd22:                     k = K_U8;
      5'd16:                                                k = K_B8;
      5'd20:                                                k = K_B3;
      default:                                              k = K_NONE;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/core/gsrp_front.sv @@
// ----------------------------------------------------------------------------
// gsrp_front
// Accepts reply characters, tracks header and token state, and queues one
// entry for every item that causes results.
// ----------------------------------------------------------------------------
module gsrp_front #(
  parameter int MAX_TOKEN_CHARS = 15
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  gsrp_pkg::in_t   in_item_i,
  input  logic            q_full_i,
  output logic            push_o,
  output gsrp_pkg::entry_t entry_o
);
  import gsrp_pkg::*;

  localparam int LW = $clog2(MAX_TOKEN_CHARS + 1);

  localparam logic [1:0] HP_WAIT = 2'd0;
  localparam logic [1:0] HP_BODY = 2'd1;
  localparam logic [1:0] HP_BAD  = 2'd2;

  localparam logic [2:0] SP_INT   = 3'd0;
  localparam logic [2:0] SP_PLUS  = 3'd1;
  localparam logic [2:0] SP_MINUS = 3'd2;
  localparam logic [2:0] SP_POS   = 3'd3;
  localparam logic [2:0] SP_NEG   = 3'd4;
  localparam logic [2:0] SP_FRAC1 = 3'd5;
  localparam logic [2:0] SP_FRAC2 = 3'd6;
  localparam logic [2:0] SP_DEAD  = 3'd7;

  logic [1:0]    hdr_q, hdr_d;
  logic [4:0]    cnt_q, cnt_d;
  logic [LW-1:0] len_q, len_d;
  logic [31:0]   acc_q, acc_d;
  logic          sat_q, sat_d;
  logic [6:0]    frac_q, frac_d;
  logic [2:0]    sp_q, sp_d;
  logic [7:0]    bits_q, bits_d;

  logic [31:0]   acc_n;
  logic          sat_n;
  logic [6:0]    frac_n;
  logic [2:0]    sp_n;
  logic [7:0]    bits_n;
  logic [LW-1:0] len_n;

  logic          accept;
  logic          dig;
  logic [3:0]    dval;
  logic [35:0]   prod;
  logic [6:0]    dten;
  kind_e         kind;
  logic          room;
  logic          fin;
  logic          use_fed;
  logic [4:0]    cnt_fin;
  logic [2:0]    sp_rec;

  assign accept = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign kind = kind_of(cnt_q);
  assign room = (cnt_q < 5'(NUM_FIELDS));
  assign dig = (in_item_i.ch >= CH_ZERO) && (in_item_i.ch <= CH_NINE);
  assign dval = dig ? in_item_i.ch[3:0] : 4'd0;
  assign prod = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {32'd0, dval};
  assign dten = ({3'd0, dval} << 3) + ({3'd0, dval} << 1);
  assign len_n = len_q + LW'(1);

  always_comb begin
    acc_n = acc_q;
    sat_n = sat_q;
    frac_n = frac_q;
    sp_n = sp_q;
    bits_n = bits_q;
    case (kind)
      K_X10, K_X100: begin
        case (sp_q)
          SP_INT: begin
            if (dig) begin
              acc_n = prod[31:0];
            end else begin
              sp_n = (in_item_i.ch == CH_DOT) ? SP_FRAC1 : SP_DEAD;
            end
          end
          SP_FRAC1: begin
            if (dig) begin
              frac_n = dten;
              sp_n = SP_FRAC2;
            end else begin
              sp_n = SP_DEAD;
            end
          end
          SP_FRAC2: begin
            if (dig) begin
              frac_n = frac_q + {3'd0, dval};
            end
            sp_n = SP_DEAD;
          end
          default: begin
          end
        endcase
      end
      K_U16, K_U8: begin
        case (sp_q)
          SP_INT: begin
            if (in_item_i.ch >= CH_TAB && in_item_i.ch <= CH_CR) begin
              sp_n = SP_INT;
            end else if (in_item_i.ch == CH_PLUS) begin
              sp_n = SP_PLUS;
            end else if (in_item_i.ch == CH_MINUS) begin
              sp_n = SP_MINUS;
            end else if (dig) begin
              acc_n = prod[31:0];
              sat_n = sat_q || (prod[35:32] != 4'd0);
              sp_n = SP_POS;
            end else begin
              sp_n = SP_DEAD;
            end
          end
          SP_PLUS, SP_MINUS: begin
            if (dig) begin
              acc_n = prod[31:0];
              sat_n = sat_q || (prod[35:32] != 4'd0);
              sp_n = (sp_q == SP_MINUS) ? SP_NEG : SP_POS;
            end else begin
              sp_n = SP_DEAD;
            end
          end
          SP_POS, SP_NEG: begin
            if (dig) begin
              acc_n = prod[31:0];
              sat_n = sat_q || (prod[35:32] != 4'd0);
            end else begin
              sp_n = SP_DEAD;
            end
          end
          default: begin
          end
        endcase
      end
      K_B8, K_B3: begin
        if (({{(32-LW){1'b0}}, len_q} < 32'd8) && (in_item_i.ch == CH_ONE)) begin
          bits_n[len_q[2:0]] = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    hdr_d = hdr_q;
    cnt_d = cnt_q;
    len_d = len_q;
    acc_d = acc_q;
    sat_d = sat_q;
    frac_d = frac_q;
    sp_d = sp_q;
    bits_d = bits_q;
    fin = 1'b0;
    use_fed = 1'b0;
    push_o = 1'b0;
    cnt_fin = cnt_q + (room ? 5'd1 : 5'd0);

    if (in_item_i.end_marker) begin
      fin = (hdr_q == HP_BODY) && (len_q != '0);
      push_o = accept;
    end else if (hdr_q == HP_BODY && in_item_i.ch != CH_SPACE) begin
      use_fed = 1'b1;
      fin = (len_n >= LW'(MAX_TOKEN_CHARS));
      push_o = accept && fin && room;
    end else if (hdr_q == HP_BODY) begin
      fin = (len_q != '0);
      push_o = accept && fin && room;
    end

    if (accept) begin
      if (in_item_i.end_marker) begin
        hdr_d = HP_WAIT;
        cnt_d = '0;
        len_d = '0;
        acc_d = '0;
        sat_d = 1'b0;
        frac_d = '0;
        sp_d = SP_INT;
        bits_d = '0;
      end else if (hdr_q == HP_WAIT) begin
        hdr_d = (in_item_i.ch == CH_LPAREN) ? HP_BODY : HP_BAD;
      end else if (hdr_q == HP_BODY) begin
        if (fin) begin
          cnt_d = cnt_fin;
          len_d = '0;
          acc_d = '0;
          sat_d = 1'b0;
          frac_d = '0;
          sp_d = SP_INT;
          bits_d = '0;
        end else if (use_fed) begin
          len_d = len_n;
          acc_d = acc_n;
          sat_d = sat_n;
          frac_d = frac_n;
          sp_d = sp_n;
          bits_d = bits_n;
        end
      end
    end
  end

  assign sp_rec = use_fed ? sp_n : sp_q;

  always_comb begin
    entry_o.has_field = fin && room;
    entry_o.tok.idx = cnt_q;
    entry_o.tok.kind = kind;
    entry_o.tok.acc = use_fed ? acc_n[15:0] : acc_q[15:0];
    entry_o.tok.sat = use_fed ? sat_n : sat_q;
    entry_o.tok.neg = (sp_rec == SP_NEG);
    entry_o.tok.frac = use_fed ? frac_n : frac_q;
    entry_o.tok.bits = use_fed ? bits_n : bits_q;
    entry_o.has_status = in_item_i.end_marker;
    if (hdr_q != HP_BODY) begin
      entry_o.status = ST_NO_PAREN;
    end else if ((fin ? cnt_fin : cnt_q) < 5'(MIN_FIELDS)) begin
      entry_o.status = ST_FEW;
    end else begin
      entry_o.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= HP_WAIT;
      cnt_q <= '0;
      len_q <= '0;
      acc_q <= '0;
      sat_q <= 1'b0;
      frac_q <= '0;
      sp_q <= SP_INT;
      bits_q <= '0;
    end else begin
      hdr_q <= hdr_d;
      cnt_q <= cnt_d;
      len_q <= len_d;
      acc_q <= acc_d;
      sat_q <= sat_d;
      frac_q <= frac_d;
      sp_q <= sp_d;
      bits_q <= bits_d;
    end
  end

endmodule

@@ rtl/core/gsrp_fifo.sv @@
// ----------------------------------------------------------------------------
// gsrp_fifo
// Short queue of result entries between the front and the back.
// ----------------------------------------------------------------------------
module gsrp_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  gsrp_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output gsrp_pkg::entry_t head_o
);
  import gsrp_pkg::*;

  entry_t           mem_q [QDEPTH];
  logic [QAW-1:0]   wptr_q, rptr_q;
  logic [QAW:0]     cnt_q;
  logic             do_pop;

  assign full_o = (cnt_q == (QAW+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o = mem_q[rptr_q];
  assign do_pop = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QAW'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + QAW'(1);
      end
      cnt_q <= cnt_q + (push_i ? (QAW+1)'(1) : '0) - (do_pop ? (QAW+1)'(1) : '0);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("Push into a full queue.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("Pop from an empty queue.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !do_pop) |=> (cnt_q == $past(cnt_q) + (QAW+1)'(1)))
    else $error("Queue count did not follow a push.");

endmodule

@@ rtl/core/gsrp_back.sv @@
// ----------------------------------------------------------------------------
// gsrp_back
// Converts queued tokens to field values and sends field and status results
// through an output register.
// ----------------------------------------------------------------------------
module gsrp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  gsrp_pkg::entry_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output gsrp_pkg::out_t   out_item_o
);
  import gsrp_pkg::*;

  logic        out_valid_q, out_valid_d;
  out_t        out_q, out_d;
  logic        sent_q, sent_d;
  logic        load;
  logic [14:0] frac_scaled;
  logic [3:0]  frac_hi;
  logic [15:0] conv;
  logic [15:0] sval;

  assign load = !out_valid_q || !out_stall_i;
  assign frac_scaled = {8'd0, head_i.tok.frac} * 15'd205;
  assign frac_hi = frac_scaled[14:11];

  always_comb begin
    if (head_i.tok.sat) begin
      sval = 16'hFFFF;
    end else if (head_i.tok.neg) begin
      sval = 16'd0 - head_i.tok.acc;
    end else begin
      sval = head_i.tok.acc;
    end
    case (head_i.tok.kind)
      K_X10:   conv = head_i.tok.acc * 16'd10 + {12'd0, frac_hi};
      K_X100:  conv = head_i.tok.acc * 16'd100 + {9'd0, head_i.tok.frac};
      K_U16:   conv = sval;
      K_U8:    conv = {8'd0, sval[7:0]};
      K_B8:    conv = {8'd0, head_i.tok.bits};
      K_B3:    conv = {13'd0, head_i.tok.bits[2:0]};
      default: conv = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d = out_q;
    sent_d = sent_q;
    pop_o = 1'b0;
    if (load) begin
      out_valid_d = !empty_i;
      if (!empty_i) begin
        if (head_i.has_field && !sent_q) begin
          out_d.field_index = head_i.tok.idx;
          out_d.value = conv;
          out_d.done_res = 1'b0;
          out_d.status = ST_OK;
          out_d.last_of_run = !head_i.has_status;
          pop_o = !head_i.has_status;
          sent_d = head_i.has_status;
        end else begin
          out_d.field_index = '0;
          out_d.value = '0;
          out_d.done_res = 1'b1;
          out_d.status = head_i.status;
          out_d.last_of_run = 1'b1;
          pop_o = 1'b1;
          sent_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sent_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sent_q <= sent_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !out_q.last_of_run) |=>
      (out_valid_q && out_q.done_res))
    else $error("Field result not followed at once by its status result.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.done_res) |->
      (out_q.last_of_run && out_q.value == '0 && out_q.field_index == '0))
    else $error("Malformed status result.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.done_res) |->
      (out_q.status == ST_OK && out_q.field_index < 5'(NUM_FIELDS)))
    else $error("Malformed field result.");

endmodule

@@ rtl/core/general_status_reply_parser.sv @@
// ----------------------------------------------------------------------------
// general_status_reply_parser
// Streaming parser for an inverter general status reply, one character per
// item, giving one result per converted field and a status at the end.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle unless a full queue stalls the input;
// an end item that closes a token gives two results, its field result and
// then its status result, both through the single output register.
// A four-entry queue between the parse front and the conversion back absorbs
// output stalls. Reset clears all parse state and empties the queue.
module general_status_reply_parser #(
  parameter int MAX_TOKEN_CHARS = 15
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  gsrp_pkg::in_t  in_item_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output gsrp_pkg::out_t out_item_o
);
  import gsrp_pkg::*;

  logic   q_full;
  logic   q_empty;
  logic   push;
  logic   pop;
  entry_t entry;
  entry_t head;

  gsrp_front #(
    .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i (in_item_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .entry_o   (entry)
  );

  gsrp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .full_o (q_full),
    .pop_i  (pop),
    .empty_o(q_empty),
    .head_o (head)
  );

  gsrp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (q_empty),
    .head_i     (head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the general status reply parser. Replies are sent one
// character per item: a short directed opening, then random replies. Most of
// them are well formed, with field text that matches each table position.
// Some are short or noisy. A scoreboard tracks the parser state, works out
// the field and status results of every accepted item, and checks each
// delivered result in order. The input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gsrp_pkg::*;

  localparam int TOKEN_CHARS = 15;
  localparam int BODY_ITEMS  = 500;

  class reply_scoreboard;
    typedef enum {HDR_WAIT, HDR_BODY, HDR_BAD} hdr_e;
    typedef enum {
      SCAN_INT, SCAN_PLUS, SCAN_MINUS, SCAN_POS, SCAN_NEG,
      SCAN_FRAC1, SCAN_FRAC2, SCAN_DEAD
    } scan_e;

    kind_e field_kind [NUM_FIELDS] = '{
      K_X10, K_X10, K_X10, K_X10, K_U16, K_U16, K_U8, K_U16,
      K_X100, K_U16, K_U8, K_U16, K_X10, K_X10, K_X100, K_U16,
      K_B8, K_U16, K_U8, K_U16, K_B3, K_U8, K_U8, K_U16};

    out_t        pending_q[$];
    out_t        fresh_q[$];
    int unsigned mismatches = 0;

    hdr_e        hdr       = HDR_WAIT;
    int unsigned tok_cnt   = 0;
    int unsigned tok_len   = 0;
    bit [31:0]   int_acc   = '0;
    bit          int_sat   = 1'b0;
    int unsigned frac      = 0;
    scan_e       scan      = SCAN_INT;
    bit [7:0]    bit_acc   = '0;

    function void clear_token();
      tok_len = 0;
      int_acc = '0;
      int_sat = 1'b0;
      frac    = 0;
      scan    = SCAN_INT;
      bit_acc = '0;
    endfunction

    function void close_token();
      kind_e     k;
      bit [31:0] v;
      out_t      r;
      if (tok_cnt < NUM_FIELDS) begin
        k = field_kind[tok_cnt];
        case (k)
          K_X10:  v = int_acc * 32'd10 + 32'(frac / 10);
          K_X100: v = int_acc * 32'd100 + 32'(frac);
          K_U16, K_U8: begin
            if (int_sat) v = '1;
            else if (scan == SCAN_NEG) v = -int_acc;
            else v = int_acc;
            if (k == K_U8) v = v & 32'hFF;
          end
          K_B8:    v = 32'(bit_acc);
          default: v = 32'(bit_acc[2:0]);
        endcase
        r = '{field_index: 5'(tok_cnt), value: v[15:0], done_res: 1'b0,
              status: ST_OK, last_of_run: 1'b0};
        fresh_q.push_back(r);
        tok_cnt++;
      end
      clear_token();
    endfunction

    function void add_digit(int unsigned d);
      bit [35:0] t;
      t = {4'b0, int_acc} * 36'd10 + 36'(d);
      if (t[35:32] != 0) int_sat = 1'b1;
      int_acc = t[31:0];
    endfunction

    function void feed(logic [7:0] c);
      kind_e       k;
      bit          is_dig;
      int unsigned d;
      k      = (tok_cnt < NUM_FIELDS) ? field_kind[tok_cnt] : K_NONE;
      is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
      d      = is_dig ? int'(c - CH_ZERO) : 0;
      case (k)
        K_X10, K_X100: begin
          case (scan)
            SCAN_INT: begin
              if (is_dig) int_acc = int_acc * 32'd10 + 32'(d);
              else scan = (c == CH_DOT) ? SCAN_FRAC1 : SCAN_DEAD;
            end
            SCAN_FRAC1: begin
              if (is_dig) begin
                frac = d * 10;
                scan = SCAN_FRAC2;
              end else begin
                scan = SCAN_DEAD;
              end
            end
            SCAN_FRAC2: begin
              if (is_dig) frac += d;
              scan = SCAN_DEAD;
            end
            default: ;
          endcase
        end
        K_U16, K_U8: begin
          case (scan)
            SCAN_INT: begin
              if (c >= CH_TAB && c <= CH_CR) begin
              end else if (c == CH_PLUS) begin
                scan = SCAN_PLUS;
              end else if (c == CH_MINUS) begin
                scan = SCAN_MINUS;
              end else if (is_dig) begin
                add_digit(d);
                scan = SCAN_POS;
              end else begin
                scan = SCAN_DEAD;
              end
            end
            SCAN_PLUS, SCAN_MINUS: begin
              if (is_dig) begin
                add_digit(d);
                scan = (scan == SCAN_MINUS) ? SCAN_NEG : SCAN_POS;
              end else begin
                scan = SCAN_DEAD;
              end
            end
            SCAN_POS, SCAN_NEG: begin
              if (is_dig) add_digit(d);
              else scan = SCAN_DEAD;
            end
            default: ;
          endcase
        end
        K_B8, K_B3: begin
          if (tok_len < 8 && c == CH_ONE) bit_acc[tok_len] = 1'b1;
        end
        default: ;
      endcase
      tok_len++;
    endfunction

    function void note_item(in_t it);
      logic [1:0] st;
      fresh_q.delete();
      if (it.end_marker) begin
        if (hdr == HDR_BODY && tok_len > 0) close_token();
        if (hdr != HDR_BODY) st = ST_NO_PAREN;
        else if (tok_cnt < MIN_FIELDS) st = ST_FEW;
        else st = ST_OK;
        fresh_q.push_back('{field_index: '0, value: '0, done_res: 1'b1,
                            status: st, last_of_run: 1'b0});
        hdr     = HDR_WAIT;
        tok_cnt = 0;
        clear_token();
      end else if (hdr == HDR_WAIT) begin
        hdr = (it.ch == CH_LPAREN) ? HDR_BODY : HDR_BAD;
      end else if (hdr == HDR_BODY) begin
        if (it.ch == CH_SPACE) begin
          if (tok_len > 0) close_token();
        end else begin
          feed(it.ch);
          if (tok_len >= TOKEN_CHARS) close_token();
        end
      end
      if (fresh_q.size() > 0) fresh_q[fresh_q.size() - 1].last_of_run = 1'b1;
      foreach (fresh_q[i]) pending_q.push_back(fresh_q[i]);
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_item(out_t got);
      out_t want;
      if (pending_q.size() == 0) begin
        $error("unexpected result: field_index %0d value %0h done_res %0b status %0d",
               got.field_index, got.value, got.done_res, got.status);
        mismatches++;
        return;
      end
      want = pending_q.pop_front();
      compare("field_index", 16'(want.field_index), 16'(got.field_index));
      compare("value", want.value, got.value);
      compare("done_res", 16'(want.done_res), 16'(got.done_res));
      compare("status", 16'(want.status), 16'(got.status));
      compare("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
    endfunction
  endclass

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_e;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_item   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_item;

  reply_scoreboard sb = new;

  int unsigned burst_left      = 0;
  int unsigned body_items      = 0;
  bit          quiet           = 1'b0;
  stall_e      stall_mode      = STALL_NONE;
  int unsigned stall_mode_left = 0;
  int unsigned stall_tick      = 0;

  general_status_reply_parser #(
    .MAX_TOKEN_CHARS(TOKEN_CHARS)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode      = stall_e'($urandom_range(0, 3));
      stall_mode_left = $urandom_range(20, 200);
    end else begin
      stall_mode_left--;
    end
    stall_tick++;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ((stall_tick % 7) < 3);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_item(out_item);
  end

  task automatic send_item(input in_t it);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                : $urandom_range(1, 12);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(it);
    if (!quiet) body_items++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] c, input logic fin);
    in_t it;
    it.ch         = c;
    it.end_marker = fin;
    send_item(it);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic send_digit();
    send_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_token(input kind_e k);
    int unsigned pick;
    logic [7:0]  c;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      repeat ($urandom_range(1, 20)) begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_SPACE) c = 8'hA0;
        send_byte(c, 1'b0);
      end
    end else begin
      case (k)
        K_X10, K_X100: begin
          repeat ((pick == 1) ? $urandom_range(8, 18) : $urandom_range(0, 4)) send_digit();
          if ($urandom_range(0, 3) != 0) begin
            send_byte(CH_DOT, 1'b0);
            repeat ($urandom_range(0, 4)) send_digit();
          end
          if (pick == 2) send_byte(CH_PLUS, 1'b0);
        end
        K_U16, K_U8: begin
          if (pick == 3) begin
            repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(CH_TAB, CH_CR)), 1'b0);
          end
          case ($urandom_range(0, 3))
            0:       send_byte(CH_PLUS, 1'b0);
            1:       send_byte(CH_MINUS, 1'b0);
            default: ;
          endcase
          repeat ((pick == 4) ? $urandom_range(10, 13) : $urandom_range(0, 6)) send_digit();
          if (pick == 5) send_byte(CH_MINUS, 1'b0);
        end
        default: begin
          repeat ($urandom_range(1, 10)) begin
            send_byte(($urandom_range(0, 1) != 0) ? CH_ONE : CH_ZERO, 1'b0);
          end
        end
      endcase
    end
  endtask

  task automatic send_reply();
    int unsigned style;
    int unsigned ntok;
    logic [7:0]  first;
    style = $urandom_range(0, 9);
    if (style == 0) begin
      first = 8'($urandom_range(0, 255));
      send_byte(first, 1'b0);
      quiet = (first != CH_LPAREN);
      repeat ($urandom_range(0, 20)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      quiet = 1'b0;
    end else begin
      send_byte(CH_LPAREN, 1'b0);
      ntok = (style == 1) ? $urandom_range(0, 8) : $urandom_range(18, 27);
      repeat ($urandom_range(0, 2)) send_byte(CH_SPACE, 1'b0);
      for (int i = 0; i < ntok; i++) begin
        send_token((i < NUM_FIELDS) ? sb.field_kind[i] : kind_e'($urandom_range(0, 5)));
        if (i + 1 < ntok || $urandom_range(0, 1) != 0) begin
          repeat ($urandom_range(1, 3)) send_byte(CH_SPACE, 1'b0);
        end
      end
    end
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    if ($urandom_range(0, 3) == 0) wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // An end item before any character, then a reply without its opening
    // parenthesis, then a short reply with a zero byte and a high byte.
    send_byte(8'hFF, 1'b1);
    send_text("Q(");
    send_byte(8'h00, 1'b1);
    send_text("( 12.345  ");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text(" -7");
    send_byte(8'h5A, 1'b1);
    wait_drained();

    while (body_items < BODY_ITEMS) send_reply();

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("** general_status_reply_parser: PASSED **");
    end else begin
      $display("** general_status_reply_parser: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** general_status_reply_parser: FAILED **");
    $finish;
  end

endmodule

@@ general_status_reply_parser.f @@
rtl/core/gsrp_pkg.sv
rtl/core/gsrp_front.sv
rtl/core/gsrp_fifo.sv
rtl/core/gsrp_back.sv
rtl/core/general_status_reply_parser.sv
verif/tb_top.sv
